// ----- rtl/core/dcw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcw_pkg
// Shared types, constants and the code-to-length table for the chain walker.
// ----------------------------------------------------------------------------
package dcw_pkg;

    localparam int unsigned ADDR_W   = 24;
    localparam int unsigned LEN_W    = 8;
    localparam int unsigned STEPS_W  = 16;
    localparam int unsigned WSTEP_W  = 17;
    localparam int unsigned CNT_W    = 32;
    localparam int unsigned TAG_W    = 32;
    localparam int unsigned CODE_W   = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned OUT_DATA_W = 224;

    localparam logic [ADDR_W-1:0] END_LINK = 24'hFF_FFFF;

    localparam logic [ADDR_W-1:0]  RAM_LIMIT_RST = 24'h20_0000;
    localparam logic [LEN_W-1:0]   MAX_LEN_RST   = 8'd32;
    localparam logic [STEPS_W-1:0] MAX_STEPS_RST = 16'd5120;

    localparam logic [CFG_IDX_W-1:0] REG_RAM_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEPS = 2'd2;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TAG   = 1'b1;

    typedef enum logic [2:0] {
        ST_CONTINUE    = 3'd0,
        ST_COMPLETE    = 3'd1,
        ST_ABORT_LEN   = 3'd2,
        ST_ABORT_RANGE = 3'd3,
        ST_ABORT_ALIGN = 3'd4,
        ST_ABORT_STEPS = 3'd5,
        ST_IGNORED     = 3'd6
    } status_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  ram_limit;
        logic [LEN_W-1:0]   max_len;
        logic [STEPS_W-1:0] max_steps;
    } cfg_t;

    typedef struct packed {
        logic               func;
        logic [ADDR_W-1:0]  start_addr;
        logic [TAG_W-1:0]   tag_word;
        logic [CODE_W-1:0]  prim_code;
    } beat_t;

    typedef struct packed {
        logic [ADDR_W-1:0] fetch_addr;
        logic              emit_packet;
        logic [ADDR_W-1:0] packet_addr;
        logic [LEN_W-1:0]  packet_len;
        logic              length_mismatch;
        status_t           walk_status;
        logic [CNT_W-1:0]  packet_total;
        logic [CNT_W-1:0]  step_total;
        logic [CNT_W-1:0]  mismatch_total;
        logic [CNT_W-1:0]  abort_total;
        logic [TAG_W-1:0]  last_tag;
    } result_t;

    // Expected payload length for a primitive code; zero when unknown.
    function automatic logic [LEN_W-1:0] expected_len(input logic [CODE_W-1:0] code);
        logic [LEN_W-1:0] len;
        len = '0;
        case (code & 8'hFC)
            8'h20:   len = 8'd4;
            8'h28:   len = 8'd5;
            8'h24:   len = 8'd7;
            8'h2C:   len = 8'd9;
            8'h30:   len = 8'd6;
            8'h38:   len = 8'd8;
            8'h34:   len = 8'd9;
            8'h3C:   len = 8'd12;
            8'h64:   len = 8'd4;
            8'h74:   len = 8'd3;
            8'h7C:   len = 8'd3;
            8'h60:   len = 8'd3;
            default: len = (code == 8'hE1) ? 8'd1 : 8'd0;
        endcase
        return len;
    endfunction

endpackage

// ----- rtl/core/dcw_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcw_cfg_regs
// Limit registers written over the configuration channel.
// ----------------------------------------------------------------------------
module dcw_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dcw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dcw_pkg::CFG_DATA_W-1:0]   cfg_data,
    output dcw_pkg::cfg_t                    cfg
);

    dcw_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ram_limit <= dcw_pkg::RAM_LIMIT_RST;
            cfg_reg.max_len   <= dcw_pkg::MAX_LEN_RST;
            cfg_reg.max_steps <= dcw_pkg::MAX_STEPS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                dcw_pkg::REG_RAM_LIMIT: cfg_reg.ram_limit <= cfg_data[dcw_pkg::ADDR_W-1:0];
                dcw_pkg::REG_MAX_LEN:   cfg_reg.max_len   <= cfg_data[dcw_pkg::LEN_W-1:0];
                dcw_pkg::REG_MAX_STEPS: cfg_reg.max_steps <= cfg_data[dcw_pkg::STEPS_W-1:0];
                default:                cfg_reg           <= cfg_reg;
            endcase
        end
    end

endmodule

// ----- rtl/core/dcw_in_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcw_in_reg
// Input register: holds one accepted beat until the walk logic consumes it.
// ----------------------------------------------------------------------------
module dcw_in_reg
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  dcw_pkg::beat_t s_beat,
    input  logic          advance,
    output logic          beat_valid,
    output dcw_pkg::beat_t beat
);

    logic           valid_reg;
    dcw_pkg::beat_t beat_reg;

    assign s_tready   = !valid_reg || advance;
    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            beat_reg <= s_beat;
        end
    end

endmodule

// ----- rtl/core/dcw_walk_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcw_walk_core
// Walk state, running counters and the per-tag check logic.
// ----------------------------------------------------------------------------
module dcw_walk_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  dcw_pkg::cfg_t    cfg,
    input  dcw_pkg::beat_t   beat,
    input  logic             advance,
    output dcw_pkg::result_t result
);

    logic                           walking_reg, walking_next;
    logic [dcw_pkg::ADDR_W-1:0]     cur_addr_reg, cur_addr_next;
    logic [dcw_pkg::WSTEP_W-1:0]    wsteps_reg, wsteps_next;
    logic [dcw_pkg::CNT_W-1:0]      pkt_cnt_reg, pkt_cnt_next;
    logic [dcw_pkg::CNT_W-1:0]      step_cnt_reg, step_cnt_next;
    logic [dcw_pkg::CNT_W-1:0]      mism_cnt_reg, mism_cnt_next;
    logic [dcw_pkg::CNT_W-1:0]      abort_cnt_reg, abort_cnt_next;
    logic [dcw_pkg::TAG_W-1:0]      last_tag_reg, last_tag_next;

    logic [dcw_pkg::LEN_W-1:0]      len;
    logic [dcw_pkg::ADDR_W-1:0]     link;
    logic [dcw_pkg::LEN_W-1:0]      exp_len;
    logic [dcw_pkg::WSTEP_W-1:0]    wsteps_inc;
    dcw_pkg::status_t               status;
    logic [dcw_pkg::ADDR_W-1:0]     fetch;
    logic                           emit;
    logic                           mism;

    assign len        = beat.tag_word[dcw_pkg::TAG_W-1:dcw_pkg::ADDR_W];
    assign link       = beat.tag_word[dcw_pkg::ADDR_W-1:0];
    assign exp_len    = dcw_pkg::expected_len(beat.prim_code);
    assign wsteps_inc = wsteps_reg + 1'b1;

    always_comb
    begin
        walking_next   = walking_reg;
        cur_addr_next  = cur_addr_reg;
        wsteps_next    = wsteps_reg;
        pkt_cnt_next   = pkt_cnt_reg;
        step_cnt_next  = step_cnt_reg;
        mism_cnt_next  = mism_cnt_reg;
        abort_cnt_next = abort_cnt_reg;
        last_tag_next  = last_tag_reg;
        fetch          = '0;
        emit           = 1'b0;
        mism           = 1'b0;
        status         = dcw_pkg::ST_CONTINUE;

        if (beat.func == dcw_pkg::FUNC_START)
        begin
            walking_next  = 1'b1;
            cur_addr_next = beat.start_addr;
            wsteps_next   = '0;
            fetch         = beat.start_addr;
        end
        else if (!walking_reg)
        begin
            status = dcw_pkg::ST_IGNORED;
        end
        else
        begin
            last_tag_next = beat.tag_word;
            if (len > cfg.max_len)
            begin
                status = dcw_pkg::ST_ABORT_LEN;
            end
            else
            begin
                if (len != '0)
                begin
                    emit         = 1'b1;
                    pkt_cnt_next = pkt_cnt_reg + 1'b1;
                    if (exp_len != '0 && exp_len != len)
                    begin
                        mism          = 1'b1;
                        mism_cnt_next = mism_cnt_reg + 1'b1;
                    end
                end
                if (link == dcw_pkg::END_LINK)
                begin
                    status = dcw_pkg::ST_COMPLETE;
                end
                else if (link >= cfg.ram_limit)
                begin
                    status = dcw_pkg::ST_ABORT_RANGE;
                end
                else if (link[1:0] != 2'b00)
                begin
                    status = dcw_pkg::ST_ABORT_ALIGN;
                end
                else
                begin
                    wsteps_next   = wsteps_inc;
                    step_cnt_next = step_cnt_reg + 1'b1;
                    if (wsteps_inc > {1'b0, cfg.max_steps})
                    begin
                        status = dcw_pkg::ST_ABORT_STEPS;
                    end
                    else
                    begin
                        fetch         = link;
                        cur_addr_next = link;
                    end
                end
            end
            if (status != dcw_pkg::ST_CONTINUE)
            begin
                walking_next = 1'b0;
                if (status != dcw_pkg::ST_COMPLETE)
                begin
                    abort_cnt_next = abort_cnt_reg + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        result.fetch_addr      = fetch;
        result.emit_packet     = emit;
        result.packet_addr     = (beat.func == dcw_pkg::FUNC_START) ? beat.start_addr
                                                                    : cur_addr_reg;
        result.packet_len      = (beat.func == dcw_pkg::FUNC_TAG && walking_reg) ? len : '0;
        result.length_mismatch = mism;
        result.walk_status     = status;
        result.packet_total    = pkt_cnt_next;
        result.step_total      = step_cnt_next;
        result.mismatch_total  = mism_cnt_next;
        result.abort_total     = abort_cnt_next;
        result.last_tag        = last_tag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walking_reg   <= 1'b0;
            cur_addr_reg  <= '0;
            wsteps_reg    <= '0;
            pkt_cnt_reg   <= '0;
            step_cnt_reg  <= '0;
            mism_cnt_reg  <= '0;
            abort_cnt_reg <= '0;
            last_tag_reg  <= '0;
        end
        else if (advance)
        begin
            walking_reg   <= walking_next;
            cur_addr_reg  <= cur_addr_next;
            wsteps_reg    <= wsteps_next;
            pkt_cnt_reg   <= pkt_cnt_next;
            step_cnt_reg  <= step_cnt_next;
            mism_cnt_reg  <= mism_cnt_next;
            abort_cnt_reg <= abort_cnt_next;
            last_tag_reg  <= last_tag_next;
        end
    end

endmodule

// ----- rtl/core/dcw_out_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcw_out_reg
// Result register on the master side; loads while the previous beat leaves.
// ----------------------------------------------------------------------------
module dcw_out_reg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             beat_valid,
    input  dcw_pkg::result_t result,
    output logic             advance,
    output logic             m_tvalid,
    input  logic             m_tready,
    output dcw_pkg::result_t m_result
);

    logic             valid_reg;
    dcw_pkg::result_t result_reg;

    assign advance  = beat_valid && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || m_tready)
        begin
            valid_reg <= beat_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

endmodule

// ----- rtl/core/descriptor_chain_walker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// descriptor_chain_walker
// Follows a linked chain of packet descriptors, one fetched tag per beat.
//
// Channel | Direction | Signals
// s_*     | in        | tvalid, tready, tuser = func, tdata = start/tag/code
// m_*     | out       | tvalid, tready, tdata = result fields
// cfg_*   | in        | valid, ready, index, data (limit registers)
//
// One beat per cycle while m_tready is high; each result passes through the input
// register and then the result register around the check logic.
// Async active-low reset clears walk state and counters and loads default limits.
// m_tready low holds the result register; one more beat waits in the input
// register before s_tready drops. cfg_ready is always high.
// ----------------------------------------------------------------------------
module descriptor_chain_walker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [0] func
    input  logic                                s_tuser,
    // [23:0] start_addr, [55:24] tag_word, [63:56] prim_code
    input  logic [dcw_pkg::IN_DATA_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [23:0] fetch_addr, [24] emit_packet, [48:25] packet_addr,
    // [56:49] packet_len, [57] length_mismatch, [60:58] walk_status,
    // [92:61] packet_total, [124:93] step_total, [156:125] mismatch_total,
    // [188:157] abort_total, [220:189] last_tag, [223:221] zero
    output logic [dcw_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dcw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dcw_pkg::CFG_DATA_W-1:0]      cfg_data
);

    dcw_pkg::cfg_t    cfg;
    dcw_pkg::beat_t   s_beat;
    dcw_pkg::beat_t   beat;
    dcw_pkg::result_t result;
    dcw_pkg::result_t m_result;
    logic             beat_valid;
    logic             advance;

    assign s_beat.func       = s_tuser;
    assign s_beat.start_addr = s_tdata[23:0];
    assign s_beat.tag_word   = s_tdata[55:24];
    assign s_beat.prim_code  = s_tdata[63:56];

    assign m_tdata = {3'b000,
                      m_result.last_tag,
                      m_result.abort_total,
                      m_result.mismatch_total,
                      m_result.step_total,
                      m_result.packet_total,
                      m_result.walk_status,
                      m_result.length_mismatch,
                      m_result.packet_len,
                      m_result.packet_addr,
                      m_result.emit_packet,
                      m_result.fetch_addr};

    dcw_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dcw_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_beat     (s_beat),
        .advance    (advance),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    dcw_walk_core u_walk_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .beat    (beat),
        .advance (advance),
        .result  (result)
    );

    dcw_out_reg u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_valid (beat_valid),
        .result     (result),
        .advance    (advance),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_result   (m_result)
    );

endmodule
